[src/sntl_pkg.sv]
// ----------------------------------------------------------------------------
// sntl_pkg
// Shared types and constants for the sorted name table lookup block.
// ----------------------------------------------------------------------------
package sntl_pkg;

    localparam int NAME_BYTES   = 32;
    localparam int ENTRY_BYTES  = 44;
    localparam int HEADER_BYTES = 16;
    localparam int MAX_ENTRIES  = 1024;
    localparam int NAME_WORDS   = (NAME_BYTES + 7) / 8;
    localparam int ENTRY_W      = $clog2(MAX_ENTRIES);
    localparam int NWORD_W      = (NAME_WORDS > 1) ? $clog2(NAME_WORDS) : 1;
    localparam int NAME_AW      = $clog2(MAX_ENTRIES * NAME_WORDS);
    localparam int POS_W        = $clog2(NAME_BYTES);
    localparam int CNT_W        = ENTRY_W + 1;

    localparam logic [31:0] TABLE_MAGIC   = 32'h4157_4C43;
    localparam logic [15:0] TABLE_VERSION = 16'd1;

    localparam logic [1:0] OP_NAME   = 2'd0;
    localparam logic [1:0] OP_INFO   = 2'd1;
    localparam logic [1:0] OP_KEY    = 2'd2;
    localparam logic [1:0] OP_SEARCH = 2'd3;

    localparam logic [1:0] ST_FOUND    = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_INVALID  = 2'd2;

    localparam logic CFG_HEADER    = 1'b0;
    localparam logic CFG_IMAGE_LEN = 1'b1;

    typedef struct packed {
        logic [1:0]  op;
        logic [9:0]  entry_index;
        logic [1:0]  word_index;
        logic [63:0] data_word;
        logic [31:0] offset_value;
        logic [31:0] packed_size;
        logic [31:0] raw_value;
        logic [4:0]  key_length;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_offset;
        logic [31:0] found_packed_size;
        logic [31:0] found_raw_size;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_PROBE, S_READ, S_CMP, S_STEP, S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic write_op;
        logic start_search;
        logic probe;
        logic read_word;
        logic cmp_word;
        logic step;
        logic emit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic valid;
        logic range_empty;
        logic cmp_decided;
        logic last_word;
        logic match;
    } t_stat;

endpackage

[src/sntl_ram.sv]
// ----------------------------------------------------------------------------
// sntl_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sntl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[src/sntl_ctrl.sv]
// ----------------------------------------------------------------------------
// sntl_ctrl
// Controller state machine for write items and the binary search.
// ----------------------------------------------------------------------------
module sntl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [1:0]        i_op,
    input  sntl_pkg::t_stat   i_stat,
    output sntl_pkg::t_cmd    o_cmd,
    output logic              o_busy,
    output sntl_pkg::t_state  o_state
);
    import sntl_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_start && i_op == OP_SEARCH) n_state = S_CHECK;
            S_CHECK: n_state = i_stat.valid ? S_PROBE : S_DONE;
            S_PROBE: n_state = i_stat.range_empty ? S_DONE : S_READ;
            S_READ:  n_state = S_CMP;
            S_CMP: begin
                if (i_stat.cmp_decided || i_stat.last_word) begin
                    n_state = S_STEP;
                end else begin
                    n_state = S_READ;
                end
            end
            S_STEP:  n_state = i_stat.match ? S_DONE : S_PROBE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.write_op     = i_start && i_op != OP_SEARCH;
                o_cmd.start_search = i_start && i_op == OP_SEARCH;
            end
            S_PROBE: o_cmd.probe     = !i_stat.range_empty;
            S_READ:  o_cmd.read_word = 1'b1;
            S_CMP:   o_cmd.cmp_word  = 1'b1;
            S_STEP:  o_cmd.step      = 1'b1;
            S_DONE:  o_cmd.emit      = 1'b1;
            default: o_cmd = '0;
        endcase
    end

    assign o_busy  = r_state != S_IDLE;
    assign o_state = r_state;
endmodule

[src/sntl_dp.sv]
// ----------------------------------------------------------------------------
// sntl_dp
// Datapath: table stores, key, search bounds, word comparator and result.
// ----------------------------------------------------------------------------
module sntl_dp (
    input  logic                i_clk,
    input  sntl_pkg::t_in_item  i_item,
    input  sntl_pkg::t_cmd      i_cmd,
    input  logic [63:0]         i_header_word,
    input  logic [31:0]         i_image_length,
    output sntl_pkg::t_stat     o_stat,
    output sntl_pkg::t_out_item o_result
);
    import sntl_pkg::*;

    logic [63:0]        r_key [NAME_WORDS];
    logic [POS_W-1:0]   r_len;
    logic signed [CNT_W:0] r_lo, r_hi;
    logic [ENTRY_W-1:0] r_mid;
    logic [NWORD_W-1:0] r_word;
    logic               r_decided, r_lt, r_match, r_valid, r_eq;
    logic [1:0]         r_status;
    t_out_item          r_result;

    logic [NAME_AW-1:0] name_waddr, name_raddr;
    logic [63:0]        name_rdata;
    logic [31:0]        off_rdata;
    logic [63:0]        size_rdata;
    logic               name_we, info_we;
    logic               idx_ok;

    assign idx_ok  = {1'b0, i_item.entry_index} < CNT_W'(MAX_ENTRIES);
    assign name_we = i_cmd.write_op && i_item.op == OP_NAME && idx_ok &&
                     {1'b0, i_item.word_index} < 3'(NAME_WORDS);
    assign info_we = i_cmd.write_op && i_item.op == OP_INFO && idx_ok;
    assign name_waddr = NAME_AW'(i_item.entry_index * NAME_WORDS +
                                 i_item.word_index);
    assign name_raddr = NAME_AW'(r_mid * NAME_WORDS + r_word);

    sntl_ram #(.WIDTH(64), .DEPTH(MAX_ENTRIES * NAME_WORDS)) u_name (
        .i_clk(i_clk), .i_we(name_we), .i_waddr(name_waddr),
        .i_wdata(i_item.data_word), .i_raddr(name_raddr), .o_rdata(name_rdata));
    sntl_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_off (
        .i_clk(i_clk), .i_we(info_we), .i_waddr(i_item.entry_index[ENTRY_W-1:0]),
        .i_wdata(i_item.offset_value), .i_raddr(r_mid), .o_rdata(off_rdata));
    sntl_ram #(.WIDTH(64), .DEPTH(MAX_ENTRIES)) u_size (
        .i_clk(i_clk), .i_we(info_we), .i_waddr(i_item.entry_index[ENTRY_W-1:0]),
        .i_wdata({i_item.raw_value, i_item.packed_size}),
        .i_raddr(r_mid), .o_rdata(size_rdata));

    // header checks
    logic [15:0] count;
    logic [37:0] need;
    logic        valid_c;
    assign count   = i_header_word[63:48];
    assign need    = 38'(count) * 38'(ENTRY_BYTES) + 38'(HEADER_BYTES);
    assign valid_c = i_image_length >= 32'(HEADER_BYTES) &&
                     i_header_word[31:0] == TABLE_MAGIC &&
                     i_header_word[47:32] == TABLE_VERSION &&
                     need <= {6'd0, i_image_length} &&
                     {1'b0, count} <= 17'(MAX_ENTRIES);

    // one name word against the key word, bytes in order
    logic             w_dec, w_lt;
    logic [POS_W:0]   pos;
    logic [7:0]       ka, nb;
    always_comb begin
        w_dec = 1'b0;
        w_lt  = 1'b0;
        pos   = '0;
        ka    = '0;
        nb    = '0;
        for (int b = 0; b < 8; b++) begin
            pos = (POS_W+1)'(r_word) * (POS_W+1)'(8) + (POS_W+1)'(b);
            ka  = r_key[r_word][b*8 +: 8];
            nb  = name_rdata[b*8 +: 8];
            if (!w_dec) begin
                if (pos < {1'b0, r_len}) begin
                    if (ka != nb) begin
                        w_dec = 1'b1;
                        w_lt  = ka < nb;
                    end else if (ka == 8'd0) begin
                        w_dec = 1'b1;
                    end
                end else if (pos == {1'b0, r_len}) begin
                    w_dec = 1'b1;
                    w_lt  = nb != 8'd0;
                end
            end
        end
    end

    // decided but equal only when the stop came from a shared zero byte, or from the key's end on a zero name byte
    function automatic logic nbz_dec();
        logic d, e;
        logic [POS_W:0] p;
        d = 1'b0;
        e = 1'b0;
        for (int b = 0; b < 8; b++) begin
            p = (POS_W+1)'(r_word) * (POS_W+1)'(8) + (POS_W+1)'(b);
            if (!d) begin
                if (p < {1'b0, r_len}) begin
                    if (r_key[r_word][b*8 +: 8] != name_rdata[b*8 +: 8]) begin
                        d = 1'b1;
                    end else if (r_key[r_word][b*8 +: 8] == 8'd0) begin
                        d = 1'b1;
                        e = 1'b1;
                    end
                end else if (p == {1'b0, r_len}) begin
                    d = 1'b1;
                    e = name_rdata[b*8 +: 8] == 8'd0;
                end
            end
        end
        return e;
    endfunction

    logic signed [CNT_W:0] mid_c;
    assign mid_c = r_lo + ((r_hi - r_lo) >>> 1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_op && i_item.op == OP_KEY &&
            {1'b0, i_item.word_index} < 3'(NAME_WORDS)) begin
            r_key[i_item.word_index[NWORD_W-1:0]] <= i_item.data_word;
        end
        if (i_cmd.start_search) begin
            r_len   <= (i_item.key_length >= 5'(NAME_BYTES - 1)) ?
                       POS_W'(NAME_BYTES - 1) : POS_W'(i_item.key_length);
            r_valid <= valid_c;
            r_lo    <= '0;
            r_hi    <= (CNT_W+1)'(count) - (CNT_W+1)'(1);
            r_match <= 1'b0;
            r_status <= valid_c ? ST_NOTFOUND : ST_INVALID;
        end
        if (i_cmd.probe) begin
            r_mid     <= ENTRY_W'(mid_c);
            r_word    <= '0;
            r_decided <= 1'b0;
            r_lt      <= 1'b0;
        end
        if (i_cmd.cmp_word) begin
            if (!r_decided) begin
                r_decided <= w_dec;
                r_lt      <= w_lt;
            end
            r_word <= r_word + 1'b1;
        end
        if (i_cmd.step) begin
            if (!r_decided || (!r_lt && r_decided && o_stat.match)) begin
                r_match  <= 1'b1;
                r_status <= ST_FOUND;
            end else if (r_lt) begin
                r_hi <= (CNT_W+1)'(r_mid) - (CNT_W+1)'(1);
            end else begin
                r_lo <= (CNT_W+1)'(r_mid) + (CNT_W+1)'(1);
            end
        end
        if (i_cmd.emit) begin
            r_result.status            <= r_status;
            r_result.found_offset      <= r_match ? off_rdata : '0;
            r_result.found_packed_size <= r_match ? size_rdata[31:0] : '0;
            r_result.found_raw_size    <= r_match ? size_rdata[63:32] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.probe) begin
            r_eq <= 1'b1;
        end else if (i_cmd.cmp_word && !r_decided && w_dec) begin
            r_eq <= !w_lt && (nbz_dec());
        end
    end

    assign o_stat.valid       = r_valid;
    assign o_stat.range_empty = r_lo > r_hi;
    assign o_stat.cmp_decided = r_decided || w_dec;
    assign o_stat.last_word   = r_word == NWORD_W'(NAME_WORDS - 1);
    assign o_stat.match       = r_decided ? r_eq : 1'b1;
    assign o_result           = r_result;
endmodule

[src/sorted_name_table_lookup_top.sv]
// ----------------------------------------------------------------------------
// sorted_name_table_lookup_top
// Sorted name table with binary search lookup.
// ----------------------------------------------------------------------------
// Write items complete in the idle state. A search runs a check state (straight
// to done on an invalid header), then per probe: probe, a read and a compare
// state per name word until decided, and step; up to 11 probes for 1024
// entries; an empty-range probe if none matched; done; then the strobe.
// The result strobe is high for one cycle; the receiver cannot stall.
// Synchronous reset returns the controller to idle, clears config and strobe.
module sorted_name_table_lookup_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  sntl_pkg::t_in_item   i_item,
    output logic                 o_valid,
    output sntl_pkg::t_out_item  o_item,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [63:0]          i_cfg_data
);
    import sntl_pkg::*;

    logic [63:0] r_header_word;
    logic [31:0] r_image_length;
    logic        r_valid;
    t_cmd        cmd;
    t_stat       stat;
    t_state      state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_word  <= '0;
            r_image_length <= '0;
            r_valid        <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_index == CFG_HEADER) r_header_word <= i_cfg_data;
            if (i_cfg_we && i_cfg_index == CFG_IMAGE_LEN) begin
                r_image_length <= i_cfg_data[31:0];
            end
            r_valid <= cmd.emit;
        end
    end

    sntl_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start && !busy),
        .i_op(i_item.op), .i_stat(stat), .o_cmd(cmd), .o_busy(busy),
        .o_state(state));

    sntl_dp u_dp (
        .i_clk(i_clk), .i_item(i_item), .i_cmd(cmd),
        .i_header_word(r_header_word), .i_image_length(r_image_length),
        .o_stat(stat), .o_result(o_item));

    assign o_valid = r_valid;

    a_emit_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> state == S_DONE) else $error("emit outside done");
    a_strobe_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe held");
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.write_op |=> !busy) else $error("write left block busy");
endmodule

[tb/sv/sorted_name_table_lookup_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_name_table_lookup_top_test
// Loads sorted name tables and search keys, runs binary searches under many
// header and image length settings, and checks every search result against
// a local model of the table and its lookup.
// ----------------------------------------------------------------------------
module sorted_name_table_lookup_top_test;
    import sntl_pkg::*;

    localparam int FILL = 64;

    typedef struct {
        t_in_item   it;
        int         gap;
        bit         hold;
    } t_pend;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_in_item    i_item = '0;
    logic        o_valid;
    t_out_item   o_item;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [63:0] i_cfg_data = '0;

    t_pend       item_q[$];
    t_out_item   lookup_q[$];

    logic [63:0] name_m [MAX_ENTRIES][NAME_WORDS];
    logic [31:0] offset_m [MAX_ENTRIES];
    logic [31:0] packed_m [MAX_ENTRIES];
    logic [31:0] raw_m [MAX_ENTRIES];
    logic [63:0] key_m [NAME_WORDS];
    logic [63:0] header_m = '0;
    logic [31:0] img_len_m = '0;

    logic [63:0] plan_name [MAX_ENTRIES][NAME_WORDS];
    int          plan_len [MAX_ENTRIES];

    int  gap_cnt = 0;
    int  in_cnt = 0;
    int  out_cnt = 0;
    int  errors = 0;
    bit  calm = 1'b0;

    sorted_name_table_lookup_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .o_item      (o_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic int compare_key(int e, int len);
        logic [7:0] a;
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            a = key_m[i >> 3][(i & 7) * 8 +: 8];
            b = name_m[e][i >> 3][(i & 7) * 8 +: 8];
            if (a != b) return (a < b) ? -1 : 1;
            if (a == 8'd0) return 0;
        end
        if (name_m[e][len >> 3][(len & 7) * 8 +: 8] != 8'd0) return -1;
        return 0;
    endfunction

    function automatic void apply_item(t_in_item it);
        t_out_item  r;
        int         len;
        int         lo;
        int         hi;
        int         mid;
        int         c;
        logic [15:0] count;
        logic [63:0] need;
        bit          ok;
        case (it.op)
            OP_NAME: name_m[it.entry_index][it.word_index] = it.data_word;
            OP_INFO: begin
                offset_m[it.entry_index] = it.offset_value;
                packed_m[it.entry_index] = it.packed_size;
                raw_m[it.entry_index] = it.raw_value;
            end
            OP_KEY: key_m[it.word_index] = it.data_word;
            default: begin
                r = '0;
                len = (it.key_length >= NAME_BYTES) ? NAME_BYTES - 1 : it.key_length;
                count = header_m[63:48];
                need = 64'(count) * ENTRY_BYTES + HEADER_BYTES;
                ok = img_len_m >= HEADER_BYTES && header_m[31:0] == TABLE_MAGIC &&
                     header_m[47:32] == TABLE_VERSION && need <= 64'(img_len_m) &&
                     count <= MAX_ENTRIES;
                if (!ok) begin
                    r.status = ST_INVALID;
                end else begin
                    r.status = ST_NOTFOUND;
                    lo = 0;
                    hi = int'(count) - 1;
                    while (lo <= hi) begin
                        mid = lo + (hi - lo) / 2;
                        c = compare_key(mid, len);
                        if (c == 0) begin
                            r.status = ST_FOUND;
                            r.found_offset = offset_m[mid];
                            r.found_packed_size = packed_m[mid];
                            r.found_raw_size = raw_m[mid];
                            break;
                        end
                        if (c < 0) hi = mid - 1;
                        else lo = mid + 1;
                    end
                end
                lookup_q.push_back(r);
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_cnt = 0;
        end else begin
            if (start && !busy) begin
                apply_item(i_item);
                in_cnt++;
            end
            if (!start || !busy) begin
                if (gap_cnt > 0) begin
                    gap_cnt--;
                    start <= 1'b0;
                end else if (item_q.size() > 0 &&
                             !(item_q[0].hold && lookup_q.size() > 0)) begin
                    i_item <= item_q[0].it;
                    gap_cnt = item_q[0].gap;
                    item_q.pop_front();
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            out_cnt++;
            if (lookup_q.size() == 0) begin
                $display("%0t: result with none expected: actual %p", $time, o_item);
                errors++;
            end else begin
                if (o_item.status !== lookup_q[0].status)
                    $display("%0t: status expected %0d actual %0d",
                             $time, lookup_q[0].status, o_item.status);
                if (o_item.found_offset !== lookup_q[0].found_offset)
                    $display("%0t: offset expected %h actual %h",
                             $time, lookup_q[0].found_offset, o_item.found_offset);
                if (o_item.found_packed_size !== lookup_q[0].found_packed_size)
                    $display("%0t: packed size expected %h actual %h", $time,
                             lookup_q[0].found_packed_size, o_item.found_packed_size);
                if (o_item.found_raw_size !== lookup_q[0].found_raw_size)
                    $display("%0t: raw size expected %h actual %h",
                             $time, lookup_q[0].found_raw_size, o_item.found_raw_size);
                if (o_item !== lookup_q[0]) errors++;
                lookup_q.pop_front();
            end
        end
    end

    initial begin
        int quiet;
        int last_in;
        int last_out;
        quiet = 0;
        last_in = 0;
        last_out = 0;
        forever begin
            @(posedge i_clk);
            if (in_cnt != last_in || out_cnt != last_out) quiet = 0;
            else quiet++;
            last_in = in_cnt;
            last_out = out_cnt;
            if (quiet >= 5000) begin
                $display("sorted_name_table_lookup_top_test: done, errors");
                $finish;
            end
        end
    end

    task automatic push_item(logic [1:0] op, int e, int w, logic [63:0] d,
                             int klen, bit hold);
        t_pend p;
        p.it.op = op;
        p.it.entry_index = e[9:0];
        p.it.word_index = w[1:0];
        p.it.data_word = d;
        p.it.offset_value = $urandom;
        p.it.packed_size = $urandom;
        p.it.raw_value = $urandom;
        p.it.key_length = klen[4:0];
        p.gap = calm ? 0 : $urandom_range(0, 3);
        p.hold = hold;
        item_q.push_back(p);
    endtask

    task automatic make_name(int e, int len);
        logic [7:0] b;
        for (int i = 0; i < NAME_BYTES; i++) begin
            if (i == 0) b = 8'h20 + 8'(e >> 5);
            else if (i == 1) b = 8'h20 + 8'(e & 31);
            else if (i < len) b = 8'($urandom_range(1, 255));
            else b = 8'h00;
            plan_name[e][i >> 3][(i & 7) * 8 +: 8] = b;
        end
        plan_len[e] = len;
        for (int w = 0; w < NAME_WORDS; w++)
            push_item(OP_NAME, e, w, plan_name[e][w], $urandom_range(0, 31), 1'b0);
        push_item(OP_INFO, e, $urandom_range(0, 3), {$urandom, $urandom},
                  $urandom_range(0, 31), 1'b0);
    endtask

    task automatic search(int ecnt, bit hold);
        logic [63:0] k [NAME_WORDS];
        int          e;
        int          len;
        int          pos;
        e = $urandom_range(0, (ecnt > 0) ? ecnt - 1 : FILL - 1);
        for (int w = 0; w < NAME_WORDS; w++) k[w] = plan_name[e][w];
        len = (plan_len[e] > 31) ? 31 : plan_len[e];
        case ($urandom_range(0, 5))
            2: len = $urandom_range(len, 31);
            3: begin
                pos = $urandom_range(0, (len > 0) ? len - 1 : 0);
                k[pos >> 3][(pos & 7) * 8 +: 8] = 8'($urandom);
            end
            4: len = $urandom_range(0, 31);
            5: begin
                for (int w = 0; w < NAME_WORDS; w++) k[w] = {$urandom, $urandom};
                len = $urandom_range(0, 31);
            end
            default: ;
        endcase
        for (int w = 0; w < NAME_WORDS; w++)
            push_item(OP_KEY, $urandom_range(0, 1023), w, k[w], $urandom_range(0, 31), 1'b0);
        push_item(OP_SEARCH, $urandom_range(0, 1023), $urandom_range(0, 3),
                  {$urandom, $urandom}, len, hold);
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (item_q.size() > 0 || start || lookup_q.size() > 0 || busy);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic idx, logic [63:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_HEADER) header_m = v;
        else img_len_m = v[31:0];
    endtask

    task automatic run_phase(logic [15:0] count, logic [15:0] ver, logic [31:0] magic,
                             logic [31:0] img, int n);
        int ecnt;
        int e;
        drain();
        cfg_write(CFG_HEADER, {count, ver, magic});
        cfg_write(CFG_IMAGE_LEN, {32'd0, img});
        calm = ($urandom_range(0, 2) == 0);
        ecnt = (count > FILL) ? FILL : count;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0: begin
                    e = $urandom_range(0, (ecnt > 0) ? ecnt - 1 : FILL - 1);
                    make_name(e, $urandom_range(2, NAME_BYTES));
                end
                1: begin
                    e = $urandom_range(0, 1023);
                    plan_len[e] = NAME_BYTES;
                    for (int w = 0; w < NAME_WORDS; w++) begin
                        plan_name[e][w] = {$urandom, $urandom};
                        push_item(OP_NAME, e, w, plan_name[e][w], 0, 1'b0);
                    end
                end
                2: push_item(OP_INFO, $urandom_range(0, 1023), 0, '1, 31, 1'b0);
                default: search(ecnt, $urandom_range(0, 30) == 0);
            endcase
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int w = 0; w < NAME_WORDS; w++) push_item(OP_KEY, 0, w, '0, 0, 1'b0);
        push_item(OP_SEARCH, 0, 0, '0, 0, 1'b0);
        push_item(OP_SEARCH, 1023, 3, '1, 31, 1'b1);
        for (int e = 0; e < FILL; e++) make_name(e, $urandom_range(2, NAME_BYTES));
        plan_len[0] = 2;
        make_name(0, 2);
        make_name(FILL - 1, NAME_BYTES);
        push_item(OP_INFO, 1023, 3, '1, 31, 1'b0);
        push_item(OP_INFO, 0, 0, '0, 0, 1'b0);

        run_phase(16'd0, TABLE_VERSION, TABLE_MAGIC, 32'd16, 8);
        run_phase(16'd1, TABLE_VERSION, TABLE_MAGIC, 32'd60, 10);
        run_phase(16'd8, TABLE_VERSION, TABLE_MAGIC, 32'hFFFF_FFFF, 20);
        run_phase(16'd40, TABLE_VERSION, TABLE_MAGIC, 32'd40 * 44 + 16, 25);
        run_phase(16'd64, TABLE_VERSION, TABLE_MAGIC, 32'd64 * 44 + 16, 20);
        run_phase(16'd40, TABLE_VERSION, 32'h4157_4C42, 32'hFFFF_FFFF, 3);
        run_phase(16'd40, 16'd2, TABLE_MAGIC, 32'hFFFF_FFFF, 3);
        run_phase(16'd0, TABLE_VERSION, TABLE_MAGIC, 32'd15, 3);
        run_phase(16'd40, TABLE_VERSION, TABLE_MAGIC, 32'd40 * 44 + 15, 3);
        run_phase(16'd1024, TABLE_VERSION, TABLE_MAGIC, 32'd1024 * 44 + 15, 3);
        run_phase(16'd1025, TABLE_VERSION, TABLE_MAGIC, 32'hFFFF_FFFF, 3);
        run_phase(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3);
        run_phase(16'd0, 16'd0, 32'd0, 32'd0, 3);
        run_phase(16'd3, TABLE_VERSION, TABLE_MAGIC, 32'd3 * 44 + 16, 10);
        drain();

        if (errors == 0) begin
            $display("sorted_name_table_lookup_top_test: done, clean");
        end else begin
            $display("sorted_name_table_lookup_top_test: done, errors");
        end
        $finish;
    end

endmodule

[sorted_name_table_lookup_top.f]
src/sntl_pkg.sv
src/sntl_ram.sv
src/sntl_ctrl.sv
src/sntl_dp.sv
src/sorted_name_table_lookup_top.sv
tb/sv/sorted_name_table_lookup_top_test.sv
